FILE: rtl/core/idct8_pkg.sv
// ---------------------------------------------------------------------------
// idct8_pkg: shared types and constants of the 8x8 inverse DCT
// Field widths, Q16 factors, prescale table, command bundle.
// ---------------------------------------------------------------------------
package idct8_pkg;

	localparam int CoefW  = 12;
	localparam int StoreW = 16;
	localparam int RowW   = 24;
	localparam int DataW  = 32;
	localparam int AddrW  = 6;
	localparam int KW     = 18;
	localparam int PreW   = 17;

	localparam logic [KW-1:0] K_SQRT2  = 18'd92682;
	localparam logic [KW-1:0] K_2C2    = 18'd121095;
	localparam logic [KW-1:0] K_C2MC6  = 18'd70936;
	localparam logic [KW-1:0] K_C2PC6  = 18'd171254;

	localparam logic [12:0] SAT_MAX = 13'sd2047;

	typedef struct packed {
		logic             cm_we;
		logic             cm_wsel;    // 0: prescaled coef, 1: final sample
		logic [AddrW-1:0] cm_waddr;
		logic [AddrW-1:0] cm_raddr;
		logic             rm_we;
		logic [AddrW-1:0] rm_waddr;
		logic [AddrW-1:0] rm_raddr;
		logic             shift_en;
		logic             src_col;    // gather from row-pass store
		logic [2:0]       wr_k;
	} cmd_t;

	// truncating Q16 constant multiply: floor(x * k / 65536)
	function automatic logic signed [DataW-1:0] qmul(input logic signed [DataW-1:0] x,
			input logic [KW-1:0] k);
		logic signed [DataW+KW:0] p;
		p = x * $signed({1'b0, k});
		return p[DataW+15:16];
	endfunction

	function automatic logic [PreW-1:0] prescale(input logic [AddrW-1:0] i);
		logic [PreW-1:0] r;
		case (i)
			6'd0: r = 17'd65536;  6'd1: r = 17'd90901;  6'd2: r = 17'd85626;
			6'd3: r = 17'd77062;  6'd4: r = 17'd65536;  6'd5: r = 17'd51491;
			6'd6: r = 17'd35467;  6'd7: r = 17'd18081;
			6'd8: r = 17'd90901;  6'd9: r = 17'd126083; 6'd10: r = 17'd118767;
			6'd11: r = 17'd106888; 6'd12: r = 17'd90901; 6'd13: r = 17'd71420;
			6'd14: r = 17'd49195; 6'd15: r = 17'd25079;
			6'd16: r = 17'd85626; 6'd17: r = 17'd118767; 6'd18: r = 17'd111876;
			6'd19: r = 17'd100686; 6'd20: r = 17'd85626; 6'd21: r = 17'd67276;
			6'd22: r = 17'd46340; 6'd23: r = 17'd23624;
			6'd24: r = 17'd77062; 6'd25: r = 17'd106888; 6'd26: r = 17'd100686;
			6'd27: r = 17'd90615; 6'd28: r = 17'd77062; 6'd29: r = 17'd60547;
			6'd30: r = 17'd41705; 6'd31: r = 17'd21261;
			6'd32: r = 17'd65536; 6'd33: r = 17'd90901; 6'd34: r = 17'd85626;
			6'd35: r = 17'd77062; 6'd36: r = 17'd65536; 6'd37: r = 17'd51491;
			6'd38: r = 17'd35467; 6'd39: r = 17'd18081;
			6'd40: r = 17'd51491; 6'd41: r = 17'd71420; 6'd42: r = 17'd67276;
			6'd43: r = 17'd60547; 6'd44: r = 17'd51491; 6'd45: r = 17'd40456;
			6'd46: r = 17'd27866; 6'd47: r = 17'd14206;
			6'd48: r = 17'd35467; 6'd49: r = 17'd49195; 6'd50: r = 17'd46340;
			6'd51: r = 17'd41705; 6'd52: r = 17'd35467; 6'd53: r = 17'd27866;
			6'd54: r = 17'd19195; 6'd55: r = 17'd9785;
			6'd56: r = 17'd18081; 6'd57: r = 17'd25079; 6'd58: r = 17'd23624;
			6'd59: r = 17'd21261; 6'd60: r = 17'd18081; 6'd61: r = 17'd14206;
			6'd62: r = 17'd9785;  6'd63: r = 17'd4988;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/idct8_ram.sv
// ---------------------------------------------------------------------------
// idct8_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module idct8_ram #(
	parameter int W = 16,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/idct8_datapath.sv
// ---------------------------------------------------------------------------
// idct8_datapath: prescale, stores and shared 8-point AAN pipeline
// Gathers eight values, runs three stages, selects one output per cycle.
// ---------------------------------------------------------------------------
module idct8_datapath (
	input  logic                                 clk,
	input  logic signed [idct8_pkg::CoefW-1:0]   coef,
	input  idct8_pkg::cmd_t                      cmd,
	output logic signed [idct8_pkg::CoefW-1:0]   sample
);

	localparam int DW = idct8_pkg::DataW;

	logic signed [29:0]                    pre_prod;
	logic [idct8_pkg::StoreW-1:0]          cm_wdata, cm_rdata;
	logic [idct8_pkg::RowW-1:0]            rm_rdata;
	logic signed [DW-1:0]                  gin;
	logic signed [DW-1:0]                  v_q [8];
	logic signed [DW-1:0]                  o_sel;
	logic signed [DW-7:0]                  o_shr;
	logic signed [idct8_pkg::CoefW-1:0]    sat;

	// stage registers
	logic signed [DW-1:0] a10_s1, a11_s1, a13_s1, t26_s1, z10_s1, z11_s1, z12_s1, z13_s1;
	logic signed [DW-1:0] a10_s2, a11_s2, a13_s2, m12_s2, d7_s2, m11_s2, z5_s2, m10_s2,
		m12b_s2;
	logic signed [DW-1:0] e0_s3, e1_s3, e2_s3, e3_s3, d7_s3, d6_s3, d5_s3, d4_s3;

	logic signed [DW-1:0] a12_c, d10_c, d12_c, d6_c, d5_c;

	assign pre_prod = coef * $signed({1'b0, idct8_pkg::prescale(cmd.cm_waddr)});

	// sample path: floor shift by 6 and clamp
	always_comb begin
		case (cmd.wr_k)
			3'd0: o_sel = e0_s3 + d7_s3;
			3'd1: o_sel = e1_s3 + d6_s3;
			3'd2: o_sel = e2_s3 + d5_s3;
			3'd3: o_sel = e3_s3 - d4_s3;
			3'd4: o_sel = e3_s3 + d4_s3;
			3'd5: o_sel = e2_s3 - d5_s3;
			3'd6: o_sel = e1_s3 - d6_s3;
			3'd7: o_sel = e0_s3 - d7_s3;
			default: o_sel = '0;
		endcase
		o_shr = o_sel[DW-1:6];
		if (o_shr > $signed({{(DW-19){1'b0}}, idct8_pkg::SAT_MAX})) begin
			sat = 12'sd2047;
		end else if (o_shr < -$signed({{(DW-19){1'b0}}, idct8_pkg::SAT_MAX}) - 1) begin
			sat = -12'sd2048;
		end else begin
			sat = o_shr[idct8_pkg::CoefW-1:0];
		end
		cm_wdata = cmd.cm_wsel ? {{(idct8_pkg::StoreW-idct8_pkg::CoefW){sat[11]}}, sat}
			: pre_prod[28:13];
	end

	idct8_ram #(.W(idct8_pkg::StoreW), .D(64)) u_cmem (
		.clk   (clk),
		.we    (cmd.cm_we),
		.waddr (cmd.cm_waddr),
		.wdata (cm_wdata),
		.raddr (cmd.cm_raddr),
		.rdata (cm_rdata)
	);

	idct8_ram #(.W(idct8_pkg::RowW), .D(64)) u_rmem (
		.clk   (clk),
		.we    (cmd.rm_we),
		.waddr (cmd.rm_waddr),
		.wdata (o_sel[idct8_pkg::RowW-1:0]),
		.raddr (cmd.rm_raddr),
		.rdata (rm_rdata)
	);

	assign sample = cm_rdata[idct8_pkg::CoefW-1:0];

	assign gin = cmd.src_col
		? {{(DW-idct8_pkg::RowW){rm_rdata[idct8_pkg::RowW-1]}}, rm_rdata}
		: {{(DW-idct8_pkg::StoreW){cm_rdata[idct8_pkg::StoreW-1]}}, cm_rdata};

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			for (int i = 0; i < 7; i++) begin
				v_q[i] <= v_q[i+1];
			end
			v_q[7] <= gin;
		end
	end

	assign a12_c = m12_s2 - a13_s2;
	assign d10_c = m10_s2 - z5_s2;
	assign d12_c = z5_s2 - m12b_s2;
	assign d6_c  = d12_c - d7_s2;
	assign d5_c  = m11_s2 - d6_c;

	always_ff @(posedge clk) begin
		a10_s1 <= v_q[0] + v_q[4];
		a11_s1 <= v_q[0] - v_q[4];
		a13_s1 <= v_q[2] + v_q[6];
		t26_s1 <= v_q[2] - v_q[6];
		z13_s1 <= v_q[5] + v_q[3];
		z10_s1 <= v_q[5] - v_q[3];
		z11_s1 <= v_q[1] + v_q[7];
		z12_s1 <= v_q[1] - v_q[7];

		a10_s2  <= a10_s1;
		a11_s2  <= a11_s1;
		a13_s2  <= a13_s1;
		m12_s2  <= idct8_pkg::qmul(t26_s1, idct8_pkg::K_SQRT2);
		d7_s2   <= z11_s1 + z13_s1;
		m11_s2  <= idct8_pkg::qmul(z11_s1 - z13_s1, idct8_pkg::K_SQRT2);
		z5_s2   <= idct8_pkg::qmul(z10_s1 + z12_s1, idct8_pkg::K_2C2);
		m10_s2  <= idct8_pkg::qmul(z12_s1, idct8_pkg::K_C2MC6);
		m12b_s2 <= idct8_pkg::qmul(z10_s1, idct8_pkg::K_C2PC6);

		e0_s3 <= a10_s2 + a13_s2;
		e3_s3 <= a10_s2 - a13_s2;
		e1_s3 <= a11_s2 + a12_c;
		e2_s3 <= a11_s2 - a12_c;
		d7_s3 <= d7_s2;
		d6_s3 <= d6_c;
		d5_s3 <= d5_c;
		d4_s3 <= d10_c + d5_c;
	end

endmodule

FILE: rtl/core/idct8_ctrl.sv
// ---------------------------------------------------------------------------
// idct8_ctrl: sequencer of the 8x8 inverse DCT
// Load, gather, pipeline wait, write-back and raster readout.
// ---------------------------------------------------------------------------
module idct8_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             valid,
	output logic             last_sample,
	output idct8_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_PIPE  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [6:0] cnt_q;
	logic [2:0] vec_q;
	logic       pass_q;
	logic [5:0] load_count_q;

	assign busy        = (state_q != S_LOAD);
	assign valid       = (state_q == S_OUT) && (cnt_q != 7'd0);
	assign last_sample = (state_q == S_OUT) && (cnt_q == 7'd64);

	always_comb begin
		cmd          = '0;
		cmd.src_col  = pass_q;
		cmd.wr_k     = cnt_q[2:0];
		cmd.rm_raddr = {cnt_q[2:0], vec_q};
		cmd.cm_raddr = {vec_q, cnt_q[2:0]};
		cmd.cm_waddr = load_count_q;
		case (state_q)
			S_LOAD: begin
				cmd.cm_we = start;
			end
			S_READ: begin
				cmd.shift_en = (cnt_q != 7'd0);
			end
			S_WRITE: begin
				cmd.rm_we    = !pass_q;
				cmd.rm_waddr = {vec_q, cnt_q[2:0]};
				cmd.cm_we    = pass_q;
				cmd.cm_wsel  = 1'b1;
				cmd.cm_waddr = {cnt_q[2:0], vec_q};
			end
			S_OUT: begin
				cmd.cm_raddr = cnt_q[5:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			cnt_q        <= '0;
			vec_q        <= '0;
			pass_q       <= 1'b0;
			load_count_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (start) begin
						load_count_q <= load_count_q + 6'd1;
						if (load_count_q == 6'd63) begin
							state_q <= S_READ;
							cnt_q   <= '0;
							vec_q   <= '0;
							pass_q  <= 1'b0;
						end
					end
				end
				S_READ: begin
					if (cnt_q == 7'd8) begin
						state_q <= S_PIPE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_PIPE: begin
					if (cnt_q == 7'd2) begin
						state_q <= S_WRITE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_WRITE: begin
					if (cnt_q == 7'd7) begin
						cnt_q <= '0;
						vec_q <= vec_q + 3'd1;
						if (vec_q == 3'd7) begin
							if (pass_q) begin
								state_q <= S_OUT;
							end else begin
								pass_q  <= 1'b1;
								state_q <= S_READ;
							end
						end else begin
							state_q <= S_READ;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_OUT: begin
					if (cnt_q == 7'd64) begin
						state_q <= S_LOAD;
						cnt_q   <= '0;
						pass_q  <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/inverse_dct_8x8_fixed_unit.sv
// ---------------------------------------------------------------------------
// inverse_dct_8x8_fixed_unit: 8x8 fixed-point AAN inverse DCT
// Loads 64 coefficients, runs row and column passes, streams 64 samples.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: coef is taken at a rising edge with start high and busy low,
//   one per cycle at most, in row-major order. Each coefficient is prescaled
//   and written to the coefficient store as it arrives.
//   After the 64th beat busy rises. Sixteen vector passes follow (eight rows,
//   then eight columns), each a gather from a store read port, a pass through
//   the shared AAN pipeline and a write-back.
//   Column results land, saturated, back in the coefficient store.
//   Readout then follows: valid marks one sample beat per cycle in
//   raster order, last_sample flags the 64th. busy falls after it.
//   A new block is only taken after readout; the block rate is set by
//   the single read port per store and the one shared pipeline.
//   The receiver cannot stall; each sample beat is present for one cycle.
//   Reset (arst_n low) returns to loading with the coefficient count at 0;
//   store contents are not cleared.
// ---------------------------------------------------------------------------
module inverse_dct_8x8_fixed_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [idct8_pkg::CoefW-1:0]  coef,
	output logic                                valid,
	output logic signed [idct8_pkg::CoefW-1:0]  sample,
	output logic                                last_sample
);

	idct8_pkg::cmd_t cmd;

	// sequencer: owns all counters and addresses
	idct8_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.valid       (valid),
		.last_sample (last_sample),
		.cmd         (cmd)
	);

	// datapath: prescale, both stores, AAN pipeline, clamp
	idct8_datapath u_dp (
		.clk    (clk),
		.coef   (coef),
		.cmd    (cmd),
		.sample (sample)
	);

	// sample beats only appear while the block is busy
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy) else $error("sample beat while idle");

	// the last sample ends the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		last_sample |=> !busy) else $error("still busy after last sample");

	// never load and read out at once
	a_no_wr_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !(cmd.cm_we || cmd.rm_we)) else $error("store write during readout");

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the 8x8 fixed-point inverse DCT
// Feeds coefficient blocks, predicts the 64 samples of each complete block
// with a local AAN model and compares every sample beat in order.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    TIMEOUT_CYC = 400000;
	localparam string PASS_MSG    = "PASS inverse_dct_8x8_fixed_unit";

	// scoreboard: holds the block being loaded and the expected sample queue
	class idct_sample_board;
		longint       pre_coef [64];
		int           fill_idx;
		logic [11:0]  sample_q [$];
		logic         last_q [$];
		int           errors;

		function new();
			fill_idx = 0;
			errors = 0;
		endfunction

		// floor(x * k / 2^16)
		function longint mul_q16(longint x, longint k);
			return (x * k) >>> 16;
		endfunction

		function void aan_pass(input longint v [8], output longint o [8]);
			longint a10, a11, a12, a13, e0, e1, e2, e3;
			longint z10, z11, z12, z13, z5, d4, d5, d6, d7, d10, d11, d12;
			a10 = v[0] + v[4];
			a11 = v[0] - v[4];
			a13 = v[2] + v[6];
			a12 = mul_q16(v[2] - v[6], 92682) - a13;
			e0 = a10 + a13; e3 = a10 - a13;
			e1 = a11 + a12; e2 = a11 - a12;
			z13 = v[5] + v[3]; z10 = v[5] - v[3];
			z11 = v[1] + v[7]; z12 = v[1] - v[7];
			d7 = z11 + z13;
			d11 = mul_q16(z11 - z13, 92682);
			z5 = mul_q16(z10 + z12, 121095);
			d10 = mul_q16(z12, 70936) - z5;
			d12 = -mul_q16(z10, 171254) + z5;
			d6 = d12 - d7;
			d5 = d11 - d6;
			d4 = d10 + d5;
			o[0] = e0 + d7; o[7] = e0 - d7;
			o[1] = e1 + d6; o[6] = e1 - d6;
			o[2] = e2 + d5; o[5] = e2 - d5;
			o[4] = e3 + d4; o[3] = e3 - d4;
		endfunction

		// one accepted coefficient beat
		function void note_coef(logic signed [11:0] c);
			longint v [8];
			longint o [8];
			longint rows [64];
			longint cols [64];
			longint s;
			pre_coef[fill_idx] =
				(longint'(c) * longint'(idct8_pkg::prescale(6'(fill_idx)))) >>> 13;
			fill_idx = (fill_idx + 1) % 64;
			if (fill_idx != 0)
				return;
			for (int r = 0; r < 8; r++) begin
				for (int k = 0; k < 8; k++)
					v[k] = pre_coef[r*8+k];
				aan_pass(v, o);
				for (int k = 0; k < 8; k++)
					rows[r*8+k] = o[k];
			end
			for (int r = 0; r < 8; r++) begin
				for (int k = 0; k < 8; k++)
					v[k] = rows[k*8+r];
				aan_pass(v, o);
				for (int k = 0; k < 8; k++)
					cols[k*8+r] = o[k];
			end
			for (int i = 0; i < 64; i++) begin
				s = cols[i] >>> 6;
				if (s < -2048) s = -2048;
				if (s > 2047) s = 2047;
				sample_q.push_back(s[11:0]);
				last_q.push_back(i == 63);
			end
		endfunction

		function void check_sample(logic [11:0] smp, logic lst);
			logic [11:0] es;
			logic        el;
			if (sample_q.size() == 0) begin
				$error("unexpected sample beat %0d", $signed(smp));
				errors++;
				return;
			end
			es = sample_q.pop_front();
			el = last_q.pop_front();
			if (smp !== es) begin
				$error("sample: expected %0d actual %0d", $signed(es), $signed(smp));
				errors++;
			end
			if (lst !== el) begin
				$error("last_sample: expected %0b actual %0b", el, lst);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [11:0] coef = '0;
	logic               busy, valid, last_sample;
	logic signed [11:0] sample;

	idct_sample_board board = new();
	int               cycle_cnt = 0;
	bit               no_gaps = 0;

	always #5 clk = ~clk;

	inverse_dct_8x8_fixed_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .coef(coef),
		.valid(valid), .sample(sample), .last_sample(last_sample)
	);

	// sample outputs and count accepted beats at the rising edge
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && valid)
			board.check_sample(sample, last_sample);
		if (arst_n && start && !busy)
			board.note_coef(coef);
		if (cycle_cnt > TIMEOUT_CYC) begin
			$display("FAIL inverse_dct_8x8_fixed_unit");
			$finish;
		end
	end

	// drive one coefficient beat; start stays high while waiting on busy
	// and drops only in idle cycles, so back-to-back beats keep it high
	task automatic send_coef(logic signed [11:0] c);
		if (!no_gaps)
			while ($urandom_range(99) < 15) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start <= 1'b1;
		coef  <= c;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_block(int kind);
		logic signed [11:0] c;
		for (int i = 0; i < 64; i++) begin
			case (kind)
				0: c = (i == 0) ? 12'sd2047 : 12'sd0;       // DC only, high
				1: c = (i == 0) ? -12'sd2048 : 12'sd0;      // DC only, low
				2: c = (i[0]) ? -12'sd2048 : 12'sd2047;     // full swing, saturates
				3: c = 12'(i * 37);                         // mixed patterns
				4: c = 12'($urandom);                       // full range noise
				default: c = ($urandom_range(3) == 0) ? 12'($urandom) :
					12'($signed($urandom_range(60)) - 30);  // typical sparse block
			endcase
			send_coef(c);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed: extremes and saturation
		for (int k = 0; k < 3; k++)
			send_block(k);
		// random: one noise block, one sparse block without gaps
		for (int b = 0; b < 2; b++) begin
			no_gaps = (b == 1);
			send_block((b == 0) ? 4 : 5);
		end
		start <= 1'b0;
		while (board.sample_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (board.errors == 0)
			$display(PASS_MSG);
		else
			$display("FAIL inverse_dct_8x8_fixed_unit");
		$finish;
	end
endmodule
